// ----- rtl/core/ohed_pkg.sv -----
// ----------------------------------------------------------------------------
// ohed_pkg
// Shared types, character constants and match helpers for the escape decoder.
// ----------------------------------------------------------------------------
package ohed_pkg;

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] HEX_MARK  = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;

  localparam int WIN_MAX = 4;
  localparam int QDEPTH  = 2;

  typedef logic [WIN_MAX-1:0][7:0] window_t;

  // results of one input word, serialized by the back end
  typedef struct packed {
    window_t    bytes;
    logic [1:0] last_idx;
    logic       last;
  } group_t;

  function automatic logic is_oct(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) d = c - CH_ZERO;
    else if ((c >= CH_LO_A) && (c <= CH_LO_F)) d = c - CH_LO_A + 8'd10;
    else if ((c >= CH_UP_A) && (c <= CH_UP_F)) d = c - CH_UP_A + 8'd10;
    return d[3:0];
  endfunction

  function automatic logic oct_full(window_t w);
    return is_oct(w[1]) && is_oct(w[2]) && is_oct(w[3]);
  endfunction

  function automatic logic hex_full(window_t w);
    return (w[1] == HEX_MARK) && is_hex(w[2]) && is_hex(w[3]);
  endfunction

  function automatic logic [7:0] oct_code(window_t w);
    logic [7:0] d1, d2, d3;
    d1 = w[1] - CH_ZERO;
    d2 = w[2] - CH_ZERO;
    d3 = w[3] - CH_ZERO;
    return {d1[1:0], d2[2:0], d3[2:0]};
  endfunction

  function automatic logic [7:0] hex_code(window_t w);
    return {hex_val(w[2]), hex_val(w[3])};
  endfunction

  // window starts with a backslash; can the held bytes still form an escape
  function automatic logic can_complete(window_t w, logic [2:0] n);
    logic oct_ok;
    logic hex_ok;
    oct_ok = 1'b1;
    hex_ok = (w[1] == HEX_MARK);
    for (int i = 1; i < WIN_MAX; i++) begin
      if (3'(i) < n && !is_oct(w[i])) oct_ok = 1'b0;
      if (i >= 2 && 3'(i) < n && !is_hex(w[i])) hex_ok = 1'b0;
    end
    return (n < 3'd2) || oct_ok || hex_ok;
  endfunction

endpackage

// ----- rtl/core/ohed_if.sv -----
// ----------------------------------------------------------------------------
// ohed_if
// Valid/ready channels for raw input words and decoded output words.
// ----------------------------------------------------------------------------
interface ohed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ohed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- rtl/core/ohed_front.sv -----
// ----------------------------------------------------------------------------
// ohed_front
// Holds the pending escape window, scans each input word and emits a group
// of up to four decoded words per input.
// ----------------------------------------------------------------------------
module ohed_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            in_ready,
  input  logic            q_full,
  output logic            q_push,
  output ohed_pkg::group_t q_data
);

  logic [2:0][7:0]  pend;
  logic [1:0]       pcnt;

  ohed_pkg::window_t w;
  ohed_pkg::window_t ob;
  logic [2:0]       n;
  logic [2:0]       k;
  logic             stop;
  logic [7:0]       emit;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    w       = {8'h00, pend};
    w[pcnt] = in_byte;
    for (int j = 1; j < ohed_pkg::WIN_MAX; j++) begin
      if (3'(j) > {1'b0, pcnt}) w[j] = 8'h00;
    end
    n    = {1'b0, pcnt} + 3'd1;
    k    = 3'd0;
    stop = 1'b0;
    emit = 8'h00;
    ob   = '0;
    for (int it = 0; it < ohed_pkg::WIN_MAX; it++) begin
      if (!stop && n != 3'd0) begin
        if (w[0] != ohed_pkg::BACKSLASH) begin
          emit = w[0];
          w    = w >> 8;
          n    = n - 3'd1;
        end else if (n == 3'd4 && ohed_pkg::oct_full(w)) begin
          emit = ohed_pkg::oct_code(w);
          n    = 3'd0;
        end else if (n == 3'd4 && ohed_pkg::hex_full(w)) begin
          emit = ohed_pkg::hex_code(w);
          n    = 3'd0;
        end else if (!in_last && n != 3'd4 && ohed_pkg::can_complete(w, n)) begin
          stop = 1'b1;
        end else begin
          emit = ohed_pkg::BACKSLASH;
          w    = w >> 8;
          n    = n - 3'd1;
        end
        if (!stop) begin
          ob[k[1:0]] = emit;
          k          = k + 3'd1;
        end
      end
    end
  end

  assign q_push          = accept && (k != 3'd0);
  assign q_data.bytes    = ob;
  assign q_data.last_idx = 2'(k - 3'd1);
  assign q_data.last     = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt <= 2'd0;
    end else if (accept) begin
      pcnt <= n[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= w[2:0];
    end
  end

endmodule

// ----- rtl/core/ohed_queue.sv -----
// ----------------------------------------------------------------------------
// ohed_queue
// Two-entry queue of result groups between front and back end.
// ----------------------------------------------------------------------------
module ohed_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ohed_pkg::group_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output ohed_pkg::group_t rdata
);

  ohed_pkg::group_t mem [ohed_pkg::QDEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'(ohed_pkg::QDEPTH));
  assign not_empty = (count != 2'd0);
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

// ----- rtl/core/ohed_back.sv -----
// ----------------------------------------------------------------------------
// ohed_back
// Serializes queued result groups into the registered output channel.
// ----------------------------------------------------------------------------
module ohed_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  ohed_pkg::group_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_last,
  input  logic             out_ready
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = !out_valid || out_ready;
  assign at_end = (idx == q_head.last_idx);
  assign q_pop  = load && q_not_empty && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= q_not_empty;
      if (q_not_empty) idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_not_empty) begin
      out_byte <= q_head.bytes[idx];
      out_last <= q_head.last && at_end;
    end
  end

endmodule

// ----- rtl/core/octal_hex_escape_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// octal_hex_escape_decoder_unit
// Backslash octal/hex escape decoder with a three-byte pending window.
// ----------------------------------------------------------------------------
// The first word of a group is written into a queue entry when its input word
// is taken and is then loaded from the queue into the output register.
// Throughput: one input word per cycle; the output side emits one word per
// cycle while out_ready allows, so an input causing N results holds the back
// end for N output words and the input stalls while two groups wait.
// Reset (rst, synchronous): empties the window, the queue and the output.
module octal_hex_escape_decoder_unit (
  input logic           clk,
  input logic           rst,
  ohed_in_if.sink       in_ch,
  ohed_out_if.source    out_ch
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_not_empty;
  ohed_pkg::group_t q_wdata;
  ohed_pkg::group_t q_head;

  ohed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.in_byte),
    .in_last  (in_ch.in_last),
    .in_ready (in_ch.ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  ohed_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_head)
  );

  ohed_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_byte    (out_ch.out_byte),
    .out_last    (out_ch.out_last),
    .out_ready   (out_ch.ready)
  );

endmodule

// ----- rtl/core/ohed_checker.sv -----
// ----------------------------------------------------------------------------
// ohed_checker
// Port-level checks for the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ohed_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && !out_ready) && !$past(rst) |->
      out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output word changed");

  a_reset_out: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  a_reset_ready: assert property (@(posedge clk) $past(rst) |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind octal_hex_escape_decoder_unit ohed_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last)
);
